// File: rtl/core/fwnf_pkg.sv
// shared types, constants and helper functions for the fixed-width number formatter
// no dependencies; used by the interfaces, the bcd converter and the top level
package fwnf_pkg;

	localparam int FIELD_BITS       = 32;
	localparam int DEF_VALUE_WIDTH  = 32;
	localparam int DEC_DIGITS       = 10;
	localparam int CNT_W            = 6;
	localparam int LINE_W           = 3;
	localparam int SCOL_W           = 5;
	localparam int COL_W            = 6;
	localparam int CHAR_W           = 7;

	localparam logic [CNT_W-1:0] DEC_LIMIT = 6'd10;
	localparam logic [CNT_W-1:0] HEX_LIMIT = 6'd8;
	localparam logic [CNT_W-1:0] BIN_LIMIT = 6'd32;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

	typedef enum logic [1:0] {
		MODE_UDEC = 2'd0,
		MODE_SDEC = 2'd1,
		MODE_HEX  = 2'd2,
		MODE_BIN  = 2'd3
	} mode_t;

	typedef logic [DEC_DIGITS-1:0][3:0] bcd_t;

	// converter status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} conv_st_t;

	function automatic logic [CNT_W-1:0] mode_limit(input mode_t m);
		logic [CNT_W-1:0] lim;
		case (m)
			MODE_UDEC: lim = DEC_LIMIT;
			MODE_SDEC: lim = DEC_LIMIT;
			MODE_HEX:  lim = HEX_LIMIT;
			default:   lim = BIN_LIMIT;
		endcase
		return lim;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + CHAR_W'(d);
		end else begin
			c = CH_A + CHAR_W'(d - 4'd10);
		end
		return c;
	endfunction

endpackage

// File: rtl/core/fwnf_if.sv
// channel interfaces: number words in, character words out
// depends on fwnf_pkg for field widths
interface fwnf_num_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        action;
	logic [fwnf_pkg::FIELD_BITS-1:0]   value;
	logic [fwnf_pkg::CNT_W-1:0]        digit_count;
	logic [fwnf_pkg::LINE_W-1:0]       line;
	logic [fwnf_pkg::SCOL_W-1:0]       start_column;

	modport source (output valid, action, value, digit_count, line, start_column,
		input ready);
	modport sink (input valid, action, value, digit_count, line, start_column,
		output ready);
endinterface

interface fwnf_chr_if;
	logic                              valid;
	logic                              ready;
	logic [fwnf_pkg::CHAR_W-1:0]       character;
	logic [fwnf_pkg::LINE_W-1:0]       out_line;
	logic [fwnf_pkg::COL_W-1:0]        out_column;
	logic                              last;

	modport source (output valid, character, out_line, out_column, last,
		input ready);
	modport sink (input valid, character, out_line, out_column, last,
		output ready);
endinterface

// File: rtl/core/fwnf_bcd.sv
// iterative binary to bcd converter, one shift-and-adjust step per cycle
// depends on fwnf_pkg (digit count, bcd and status types)
module fwnf_bcd #(
	parameter int VAL_W = fwnf_pkg::DEF_VALUE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [VAL_W-1:0]     bin,
	output fwnf_pkg::bcd_t       bcd,
	output fwnf_pkg::conv_st_t   st
);

	localparam int STEP_W = $clog2(VAL_W + 1);

	logic [VAL_W-1:0]    bin_q;
	fwnf_pkg::bcd_t      bcd_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic                done_q;
	fwnf_pkg::bcd_t      adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int k = 0; k < fwnf_pkg::DEC_DIGITS; k++) begin
			adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			bcd_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				bin_q  <= bin;
				bcd_q  <= '0;
				step_q <= STEP_W'(VAL_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				{bcd_q, bin_q} <= {adj[fwnf_pkg::DEC_DIGITS-1:0], bin_q} << 1;
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign bcd     = bcd_q;
	assign st.busy = busy_q;
	assign st.done = done_q;

endmodule

// File: rtl/core/fixed_width_number_formatter.sv
// Fixed-width number formatter: turns one number word into a run of ASCII
// character words, most significant digit first, each tagged with line and column.
// Channels: number (sink) takes action, value, digit_count, line, start_column;
// text (source) gives character, out_line, out_column and last on the final one.
// A word is taken when valid and ready are both high.
// number.ready is high only while the sequencer is idle; one word is worked at a time.
// Decimal modes first run the bcd converter: one shift-and-adjust step per bit of
// VALUE_WIDTH (capped at 32); the sequencer starts it and waits for its done strobe.
// Then one character leaves per cycle while text.ready stays high; hex and binary
// words go straight to the characters, with no conversion step.
// A sign character comes first in signed decimal mode, even with a count of zero.
// A count over the mode limit (10, 10, 8, 32) is cut to it; zero in the other modes
// gives no character at all.
// The output register holds its word while text.ready is low and the sequencer waits;
// the final word of a run may still wait while the next number word is taken.
// Reset (arst_n low) empties the output register and returns the sequencer to idle.
// Depends on fwnf_pkg, fwnf_if and fwnf_bcd.
module fixed_width_number_formatter #(
	parameter int VALUE_WIDTH = fwnf_pkg::DEF_VALUE_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	fwnf_num_if.sink           number,
	fwnf_chr_if.source         text
);

	localparam int FB    = fwnf_pkg::FIELD_BITS;
	localparam int EFF_W = (VALUE_WIDTH > FB) ? FB : VALUE_WIDTH;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_EMIT
	} state_t;

	state_t                          state_q;
	fwnf_pkg::mode_t                 mode_q;
	logic [EFF_W-1:0]                mag_q;
	logic [fwnf_pkg::CNT_W-1:0]      cnt_q;
	logic [fwnf_pkg::LINE_W-1:0]     line_q;
	logic [fwnf_pkg::COL_W-1:0]      col_q;
	logic                            sign_q;
	logic                            neg_q;

	logic                            ovalid_q;
	logic [fwnf_pkg::CHAR_W-1:0]     ochar_q;
	logic [fwnf_pkg::LINE_W-1:0]     oline_q;
	logic [fwnf_pkg::COL_W-1:0]      ocol_q;
	logic                            olast_q;

	fwnf_pkg::mode_t                 in_mode;
	logic [EFF_W-1:0]                in_val;
	logic                            in_neg;
	logic [fwnf_pkg::CNT_W-1:0]      in_lim;
	logic [fwnf_pkg::CNT_W-1:0]      in_cnt;
	logic                            accept;
	logic                            conv_start;

	fwnf_pkg::bcd_t                  bcd;
	fwnf_pkg::conv_st_t              conv_st;

	logic [FB-1:0]                   val_wide;
	logic [FB/4-1:0][3:0]            val_nib;
	logic [fwnf_pkg::CNT_W-1:0]      pos;
	logic [3:0]                      dig;
	logic                            slot_free;
	logic                            pending;
	logic                            load;
	logic [fwnf_pkg::CHAR_W-1:0]     nchar;
	logic                            nlast;

	assign in_mode = fwnf_pkg::mode_t'(number.action);
	assign in_val  = number.value[EFF_W-1:0];
	assign in_neg  = (in_mode == fwnf_pkg::MODE_SDEC) && in_val[EFF_W-1];
	assign in_lim  = fwnf_pkg::mode_limit(in_mode);
	assign in_cnt  = (number.digit_count > in_lim) ? in_lim : number.digit_count;

	assign number.ready = (state_q == S_IDLE);
	assign accept       = number.valid && number.ready;
	assign conv_start   = accept && ((in_mode == fwnf_pkg::MODE_UDEC) ||
		(in_mode == fwnf_pkg::MODE_SDEC));

	fwnf_bcd #(
		.VAL_W (EFF_W)
	) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.bin    (in_neg ? EFF_W'(~in_val + 1'b1) : in_val),
		.bcd    (bcd),
		.st     (conv_st)
	);

	// digit selection for the character at position cnt_q-1
	assign val_wide = FB'(mag_q);
	assign val_nib  = val_wide;
	assign pos      = cnt_q - 1'b1;

	always_comb begin
		case (mode_q)
			fwnf_pkg::MODE_UDEC: dig = bcd[pos[3:0]];
			fwnf_pkg::MODE_SDEC: dig = bcd[pos[3:0]];
			fwnf_pkg::MODE_HEX:  dig = val_nib[pos[2:0]];
			default:             dig = {3'b000, val_wide[pos[4:0]]};
		endcase
	end

	assign pending   = sign_q || (cnt_q != '0);
	assign slot_free = !ovalid_q || text.ready;
	assign load      = (state_q == S_EMIT) && pending && slot_free;

	always_comb begin
		if (sign_q) begin
			nchar = neg_q ? fwnf_pkg::CH_MINUS : fwnf_pkg::CH_PLUS;
			nlast = (cnt_q == '0);
		end else begin
			nchar = fwnf_pkg::digit_char(dig);
			nlast = (cnt_q == fwnf_pkg::CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= fwnf_pkg::MODE_UDEC;
			mag_q    <= '0;
			cnt_q    <= '0;
			line_q   <= '0;
			col_q    <= '0;
			sign_q   <= 1'b0;
			neg_q    <= 1'b0;
			ovalid_q <= 1'b0;
			ochar_q  <= '0;
			oline_q  <= '0;
			ocol_q   <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (text.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q  <= in_mode;
						mag_q   <= in_val;
						cnt_q   <= in_cnt;
						line_q  <= number.line;
						col_q   <= fwnf_pkg::COL_W'(number.start_column);
						sign_q  <= (in_mode == fwnf_pkg::MODE_SDEC);
						neg_q   <= in_neg;
						state_q <= conv_start ? S_CONV : S_EMIT;
					end
				end
				S_CONV: begin
					if (conv_st.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!pending) begin
						state_q <= S_IDLE;
					end else if (load) begin
						ovalid_q <= 1'b1;
						ochar_q  <= nchar;
						oline_q  <= line_q;
						ocol_q   <= col_q;
						olast_q  <= nlast;
						col_q    <= col_q + 1'b1;
						if (sign_q) begin
							sign_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
						if (nlast) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign text.valid      = ovalid_q;
	assign text.character  = ochar_q;
	assign text.out_line   = oline_q;
	assign text.out_column = ocol_q;
	assign text.last       = olast_q;

`ifndef NO_ASSERTIONS
	// converter may only run while a decimal word is being prepared
	a_conv_only_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		conv_st.busy |-> (state_q == S_CONV))
		else $error("bcd converter busy outside conversion");

	// remaining digit count never exceeds the widest mode limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fwnf_pkg::BIN_LIMIT)
		else $error("digit count beyond limit");

	// a word marked last leaves nothing pending and the sequencer idle
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(load && nlast) |=> ((state_q == S_IDLE) && !sign_q && (cnt_q == '0)))
		else $error("run not finished after last word");

	// nothing is loaded into the output register while a word still waits there
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!ovalid_q || text.ready))
		else $error("output word overwritten while stalled");
`endif

endmodule

// File: bench/fixed_width_number_formatter_tb.sv
`timescale 1ns / 100ps
// testbench for fixed_width_number_formatter: directed table then random number words,
// every character word checked against the table's expected text or a local formatter model
// depends on fwnf_pkg, fwnf_if and the formatter rtl
module fixed_width_number_formatter_tb;
	import fwnf_pkg::*;

	typedef struct {
		mode_t             act;
		logic [31:0]       value;
		logic [CNT_W-1:0]  cnt;
		logic [LINE_W-1:0] ln;
		logic [SCOL_W-1:0] scol;
	} num_word_t;

	typedef struct {
		num_word_t word;
		bit        known;
		string     text;
	} table_row_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [LINE_W-1:0] ln;
		logic [COL_W-1:0]  col;
		logic              last;
	} char_word_t;

	logic clk;
	logic arst_n;

	fwnf_num_if num_ch ();
	fwnf_chr_if txt_ch ();

	fixed_width_number_formatter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (num_ch),
		.text   (txt_ch)
	);

	char_word_t awaited_chars[$];
	table_row_t number_table[$];
	int         char_failures;
	int         send_idle_pct;
	int         recv_idle_pct;
	bit         hold_req;
	int         hold_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous bound on the whole run
	initial begin
		#5ms;
		$display("fixed_width_number_formatter_tb: FAIL");
		$finish;
	end

	task automatic push_char(input logic [CHAR_W-1:0] ch, input num_word_t w, input int k,
		input bit last);
		char_word_t c;
		c.ch   = ch;
		c.ln   = w.ln;
		c.col  = COL_W'(w.scol) + COL_W'(k);
		c.last = last;
		awaited_chars.push_back(c);
	endtask

	// characters of one number word, most significant digit first
	task automatic format_number(input num_word_t w);
		logic [CNT_W-1:0]  lim;
		logic [CNT_W-1:0]  n;
		logic [31:0]       mag;
		logic [3:0]        dg;
		longint unsigned   p;
		int                k;
		int                e;
		case (w.act)
			MODE_UDEC, MODE_SDEC: lim = DEC_LIMIT;
			MODE_HEX:             lim = HEX_LIMIT;
			default:              lim = BIN_LIMIT;
		endcase
		n   = (w.cnt > lim) ? lim : w.cnt;
		mag = w.value;
		k   = 0;
		if (w.act == MODE_SDEC) begin
			push_char(w.value[31] ? CH_MINUS : CH_PLUS, w, k, n == 0);
			// most negative value wraps to its own unsigned magnitude
			if (w.value[31]) begin
				mag = -w.value;
			end
			k++;
		end
		for (int i = 0; i < int'(n); i++) begin
			e = int'(n) - 1 - i;
			case (w.act)
				MODE_HEX: dg = 4'((mag >> (4 * e)) & 32'hF);
				MODE_BIN: dg = 4'((mag >> e) & 32'h1);
				default: begin
					p = 1;
					repeat (e) p = p * 10;
					dg = 4'(({32'b0, mag} / p) % 10);
				end
			endcase
			push_char((dg < 4'd10) ? CH_ZERO + 7'(dg) : CH_A + 7'(dg - 4'd10), w, k,
				i == int'(n) - 1);
			k++;
		end
	endtask

	task automatic add_row(input mode_t act, input logic [31:0] value,
		input logic [CNT_W-1:0] cnt, input logic [LINE_W-1:0] ln,
		input logic [SCOL_W-1:0] scol, input bit known, input string text);
		table_row_t r;
		r.word  = '{act, value, cnt, ln, scol};
		r.known = known;
		r.text  = text;
		number_table.push_back(r);
	endtask

	task automatic offer_number(input num_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			num_ch.valid <= 1'b0;
			@(negedge clk);
		end
		num_ch.valid        <= 1'b1;
		num_ch.action       <= w.act;
		num_ch.value        <= w.value;
		num_ch.digit_count  <= w.cnt;
		num_ch.line         <= w.ln;
		num_ch.start_column <= w.scol;
		do @(posedge clk); while (!num_ch.ready);
	endtask

	function automatic num_word_t random_number();
		num_word_t  w;
		logic [5:0] lim;
		w.act = mode_t'($urandom_range(3));
		case ($urandom_range(3))
			0: w.value = $urandom_range(0, 999);
			1: w.value = ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
				^ 32'($urandom_range(0, 15));
			default: w.value = $urandom;
		endcase
		case (w.act)
			MODE_UDEC, MODE_SDEC: lim = DEC_LIMIT;
			MODE_HEX:             lim = HEX_LIMIT;
			default:              lim = BIN_LIMIT;
		endcase
		// mostly within the mode limit, now and then anything the field holds
		if ($urandom_range(7) == 0) begin
			w.cnt = CNT_W'($urandom_range(0, 63));
		end else begin
			w.cnt = CNT_W'($urandom_range(0, int'(lim)));
		end
		w.ln   = LINE_W'($urandom_range(0, 7));
		w.scol = SCOL_W'($urandom_range(0, 31));
		return w;
	endfunction

	task automatic run_random(input int n_words);
		num_word_t w;
		repeat (n_words) begin
			w = random_number();
			offer_number(w);
			format_number(w);
		end
	endtask

	// sender stops until every character word is back, then lets the converter settle
	task automatic drain_text();
		@(negedge clk);
		num_ch.valid <= 1'b0;
		while (awaited_chars.size() != 0) @(posedge clk);
		repeat (64) @(negedge clk);
	endtask

	task automatic note_failure(input string msg);
		char_failures++;
		if (char_failures <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			txt_ch.ready <= 1'b0;
		end else begin
			txt_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		char_word_t want;
		if (arst_n && txt_ch.valid && txt_ch.ready) begin
			if (awaited_chars.size() == 0) begin
				note_failure($sformatf("unexpected word char %02h line %0d col %0d last %0b",
					txt_ch.character, txt_ch.out_line, txt_ch.out_column, txt_ch.last));
			end else begin
				want = awaited_chars.pop_front();
				if (txt_ch.character !== want.ch || txt_ch.out_line !== want.ln ||
					txt_ch.out_column !== want.col || txt_ch.last !== want.last) begin
					note_failure($sformatf(
						"mismatch char %02h/%02h line %0d/%0d col %0d/%0d last %0b/%0b",
						want.ch, txt_ch.character, want.ln, txt_ch.out_line,
						want.col, txt_ch.out_column, want.last, txt_ch.last));
				end
			end
		end
	end

	initial begin
		num_ch.valid        = 1'b0;
		num_ch.action       = MODE_UDEC;
		num_ch.value        = '0;
		num_ch.digit_count  = '0;
		num_ch.line         = '0;
		num_ch.start_column = '0;
		txt_ch.ready        = 1'b0;
		char_failures       = 0;
		hold_req            = 1'b0;
		hold_left           = 0;
		send_idle_pct       = 20;
		recv_idle_pct       = 48;
		arst_n              = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_row(MODE_UDEC, 32'hFFFF_FFFF, 6'd10, 3'd1, 5'd1,  1, "4294967295");
		add_row(MODE_UDEC, 32'h0000_0000, 6'd10, 3'd2, 5'd1,  1, "0000000000");
		add_row(MODE_SDEC, 32'h8000_0000, 6'd10, 3'd3, 5'd2,  1, "-2147483648");
		add_row(MODE_SDEC, 32'h7FFF_FFFF, 6'd10, 3'd4, 5'd3,  1, "+2147483647");
		add_row(MODE_SDEC, 32'h0000_0000, 6'd0,  3'd1, 5'd16, 1, "+");
		add_row(MODE_SDEC, 32'hFFFF_FFFF, 6'd0,  3'd2, 5'd5,  1, "-");
		add_row(MODE_UDEC, 32'd123,       6'd0,  3'd1, 5'd1,  1, "");
		add_row(MODE_HEX,  32'h0000_0000, 6'd0,  3'd1, 5'd1,  1, "");
		add_row(MODE_BIN,  32'd5,         6'd0,  3'd1, 5'd1,  1, "");
		add_row(MODE_HEX,  32'hDEAD_BEEF, 6'd8,  3'd3, 5'd4,  1, "DEADBEEF");
		add_row(MODE_HEX,  32'h1234_5678, 6'd63, 3'd4, 5'd9,  1, "12345678");
		add_row(MODE_UDEC, 32'hFFFF_FFFF, 6'd63, 3'd1, 5'd7,  1, "4294967295");
		add_row(MODE_UDEC, 32'd1234567,   6'd3,  3'd7, 5'd31, 1, "567");
		add_row(MODE_SDEC, 32'hFFFF_FFFF, 6'd1,  3'd2, 5'd1,  1, "-1");
		add_row(MODE_HEX,  32'hFEDC_BA98, 6'd2,  3'd0, 5'd0,  1, "98");
		add_row(MODE_BIN,  32'd1,         6'd1,  3'd4, 5'd16, 1, "1");
		add_row(MODE_BIN,  32'hFFFF_FFFF, 6'd63, 3'd1, 5'd1,  0, "");
		add_row(MODE_BIN,  32'hAAAA_AAAA, 6'd32, 3'd5, 5'd31, 0, "");
		add_row(MODE_SDEC, 32'h8000_0000, 6'd63, 3'd0, 5'd31, 0, "");
		add_row(MODE_HEX,  32'hABCD_EF01, 6'd6,  3'd6, 5'd10, 0, "");
		add_row(MODE_SDEC, 32'd305419896, 6'd5,  3'd3, 5'd12, 0, "");
		add_row(MODE_UDEC, 32'd1000000000, 6'd9, 3'd2, 5'd20, 0, "");

		foreach (number_table[r]) begin
			offer_number(number_table[r].word);
			if (number_table[r].known) begin
				for (int k = 0; k < number_table[r].text.len(); k++) begin
					push_char(7'(number_table[r].text[k]), number_table[r].word, k,
						k == number_table[r].text.len() - 1);
				end
			end else begin
				format_number(number_table[r].word);
			end
		end
		run_random(30);
		drain_text();

		send_idle_pct = 48;
		recv_idle_pct = 20;
		run_random(25);
		drain_text();

		// no idling; the receiver first holds off long enough to back up the input
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req      = 1'b1;
		run_random(25);
		drain_text();

		if (char_failures == 0) begin
			$display("fixed_width_number_formatter_tb: PASS");
		end else begin
			$display("fixed_width_number_formatter_tb: FAIL");
		end
		$finish;
	end

endmodule
